// File: rtl/jts_pkg.sv
// shared types and constants for the json token scanner
package jts_pkg;

  localparam logic [2:0] KIND_OBJECT = 3'd0;
  localparam logic [2:0] KIND_ARRAY  = 3'd1;
  localparam logic [2:0] KIND_END    = 3'd2;
  localparam logic [2:0] KIND_VALUE  = 3'd3;
  localparam logic [2:0] KIND_BUFEND = 3'd4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;

  localparam int FIELD_BITS = 16;
  localparam int MAX_RECS   = 3;

  typedef struct packed {
    logic [2:0]            kind;
    logic [FIELD_BITS-1:0] name_start;
    logic [FIELD_BITS-1:0] name_length;
    logic [FIELD_BITS-1:0] value_start;
    logic [FIELD_BITS-1:0] value_length;
  } rec_t;

  typedef struct packed {
    logic [1:0]               cnt;
    rec_t [MAX_RECS-1:0]      recs;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } push_t;

endpackage

// File: rtl/jts_if.sv
// request channel interfaces for bytes in and tokens out
interface jts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;
  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface jts_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] name_start;
  logic [15:0] name_length;
  logic [15:0] value_start;
  logic [15:0] value_length;
  logic        run_end;
  modport source (output valid, output token_kind, output name_start, output name_length,
                  output value_start, output value_length, output run_end, input ready);
  modport sink (input valid, input token_kind, input name_start, input name_length,
                input value_start, input value_length, input run_end, output ready);
endinterface

// File: rtl/jts_front.sv
// front end: accepts bytes, tracks scanner state, builds result groups
module jts_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  jts_byte_if.sink       text,
  input  logic           full,
  output jts_pkg::push_t push
);
  import jts_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic                     reading_name, reading_name_next;
  logic                     inside_quotes, inside_quotes_next;
  logic                     line_comment, line_comment_next;
  logic                     block_comment, block_comment_next;
  logic                     saw_star, saw_star_next;
  logic                     saw_slash, saw_slash_next;
  logic [POSITION_BITS-1:0] name_start, name_start_next;
  logic [POSITION_BITS-1:0] name_length, name_length_next;
  logic [POSITION_BITS-1:0] value_start, value_start_next;
  logic [POSITION_BITS-1:0] value_length, value_length_next;

  logic       accept;
  logic [7:0] c;
  logic       skip;
  logic [1:0] n;
  rec_t [MAX_RECS-1:0] recs;

  function automatic rec_t make_rec(logic [2:0] k, logic [POSITION_BITS-1:0] ns,
                                    logic [POSITION_BITS-1:0] nl,
                                    logic [POSITION_BITS-1:0] vs,
                                    logic [POSITION_BITS-1:0] vl);
    rec_t       r;
    logic [31:0] ns_w, nl_w, vs_w, vl_w;
    ns_w = 32'(ns);
    nl_w = 32'(nl);
    vs_w = 32'(vs);
    vl_w = 32'(vl);
    r.kind         = k;
    r.name_start   = (nl != '0) ? ns_w[FIELD_BITS-1:0] : '0;
    r.name_length  = nl_w[FIELD_BITS-1:0];
    r.value_start  = (vl != '0) ? vs_w[FIELD_BITS-1:0] : '0;
    r.value_length = vl_w[FIELD_BITS-1:0];
    return r;
  endfunction

  assign text.ready = !full;
  assign accept     = text.valid && !full;
  assign c          = text.text_byte;

  always_comb begin
    byte_position_next = byte_position;
    reading_name_next  = reading_name;
    inside_quotes_next = inside_quotes;
    line_comment_next  = line_comment;
    block_comment_next = block_comment;
    saw_star_next      = saw_star;
    saw_slash_next     = saw_slash;
    name_start_next    = name_start;
    name_length_next   = name_length;
    value_start_next   = value_start;
    value_length_next  = value_length;
    recs = '0;
    n    = 2'd0;
    skip = 1'b0;

    // comment and whitespace filter
    if (!inside_quotes) begin
      skip = 1'b1;
      if (line_comment) begin
        if (c == CH_CR || c == CH_LF) line_comment_next = 1'b0;
      end else if (block_comment) begin
        if (saw_star && c == CH_SLASH) begin
          block_comment_next = 1'b0;
          saw_star_next      = 1'b0;
          saw_slash_next     = 1'b0;
        end else begin
          saw_star_next = (c == CH_STAR);
        end
      end else if (c == CH_SLASH) begin
        if (saw_slash) begin
          line_comment_next = 1'b1;
          saw_slash_next    = 1'b0;
        end else begin
          saw_slash_next = 1'b1;
        end
      end else if (c == CH_STAR && saw_slash) begin
        block_comment_next = 1'b1;
        saw_slash_next     = 1'b0;
        saw_star_next      = 1'b0;
      end else if (c > CH_SPACE) begin
        skip           = 1'b0;
        saw_slash_next = 1'b0;
        saw_star_next  = 1'b0;
      end
    end

    // token handling
    if (!skip) begin
      if (c == CH_QUOTE) begin
        inside_quotes_next = !inside_quotes;
      end else if (inside_quotes) begin
        if (reading_name) begin
          if (name_length == '0) name_start_next = byte_position;
          if (name_length != POS_MAX) name_length_next = name_length + POSITION_BITS'(1);
        end else begin
          if (value_length == '0) value_start_next = byte_position;
          if (value_length != POS_MAX) value_length_next = value_length + POSITION_BITS'(1);
        end
      end else if (c == CH_LBRACE || c == CH_LBRACK) begin
        recs[0] = make_rec((c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY,
                           name_start, name_length, '0, '0);
        n = 2'd1;
        reading_name_next  = 1'b1;
        inside_quotes_next = 1'b0;
        name_start_next    = '0;
        name_length_next   = '0;
        value_start_next   = '0;
        value_length_next  = '0;
      end else if (reading_name) begin
        if (c == CH_COMMA) begin
          if (name_length != '0) begin
            recs[0] = make_rec(KIND_VALUE, '0, '0, name_start, name_length);
            n = 2'd1;
            reading_name_next  = 1'b1;
            inside_quotes_next = 1'b0;
            name_start_next    = '0;
            name_length_next   = '0;
            value_start_next   = '0;
            value_length_next  = '0;
          end
        end else if (c == CH_RBRACK || c == CH_RBRACE) begin
          if (name_length != '0) begin
            recs[0] = make_rec(KIND_VALUE, '0, '0, name_start, name_length);
            recs[1] = make_rec(KIND_END, '0, '0, '0, '0);
            n = 2'd2;
          end else begin
            recs[0] = make_rec(KIND_END, '0, '0, '0, '0);
            n = 2'd1;
          end
          reading_name_next  = 1'b1;
          inside_quotes_next = 1'b0;
          name_start_next    = '0;
          name_length_next   = '0;
          value_start_next   = '0;
          value_length_next  = '0;
        end else if (c == CH_COLON) begin
          reading_name_next = 1'b0;
        end else begin
          if (name_length == '0) name_start_next = byte_position;
          if (name_length != POS_MAX) name_length_next = name_length + POSITION_BITS'(1);
        end
      end else begin
        if (c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE) begin
          recs[0] = make_rec(KIND_VALUE, name_start, name_length, value_start, value_length);
          n = 2'd1;
          if (c != CH_COMMA) begin
            recs[1] = make_rec(KIND_END, '0, '0, '0, '0);
            n = 2'd2;
          end
          reading_name_next  = 1'b1;
          inside_quotes_next = 1'b0;
          name_start_next    = '0;
          name_length_next   = '0;
          value_start_next   = '0;
          value_length_next  = '0;
        end else begin
          if (value_length == '0) value_start_next = byte_position;
          if (value_length != POS_MAX) value_length_next = value_length + POSITION_BITS'(1);
        end
      end
    end

    if (byte_position != POS_MAX) byte_position_next = byte_position + POSITION_BITS'(1);

    // end of buffer closes the run and restores reset state
    if (text.final_byte) begin
      recs[n] = make_rec(KIND_BUFEND, name_start_next, name_length_next,
                         value_start_next, value_length_next);
      n = n + 2'd1;
      byte_position_next = '0;
      reading_name_next  = 1'b1;
      inside_quotes_next = 1'b0;
      line_comment_next  = 1'b0;
      block_comment_next = 1'b0;
      saw_star_next      = 1'b0;
      saw_slash_next     = 1'b0;
      name_start_next    = '0;
      name_length_next   = '0;
      value_start_next   = '0;
      value_length_next  = '0;
    end
  end

  assign push.valid    = accept && (n != 2'd0);
  assign push.grp.cnt  = n;
  assign push.grp.recs = recs;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      reading_name  <= 1'b1;
      inside_quotes <= 1'b0;
      line_comment  <= 1'b0;
      block_comment <= 1'b0;
      saw_star      <= 1'b0;
      saw_slash     <= 1'b0;
      name_start    <= '0;
      name_length   <= '0;
      value_start   <= '0;
      value_length  <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      reading_name  <= reading_name_next;
      inside_quotes <= inside_quotes_next;
      line_comment  <= line_comment_next;
      block_comment <= block_comment_next;
      saw_star      <= saw_star_next;
      saw_slash     <= saw_slash_next;
      name_start    <= name_start_next;
      name_length   <= name_length_next;
      value_start   <= value_start_next;
      value_length  <= value_length_next;
    end
  end

endmodule

// File: rtl/jts_queue.sv
// two-entry queue of result groups between front and back
module jts_queue (
  input  logic            clk,
  input  logic            rst,
  input  jts_pkg::push_t  push,
  output logic            full,
  output logic            head_valid,
  output jts_pkg::group_t head,
  input  logic            pop
);
  import jts_pkg::*;

  group_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) entries[wr_ptr] <= push.grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push.valid} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/jts_back.sv
// back end: unpacks result groups into single token requests
module jts_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  jts_pkg::group_t head,
  output logic            pop,
  jts_token_if.source     tokens
);
  import jts_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       last;
  rec_t       cur;

  assign load = head_valid && (!tokens.valid || tokens.ready);
  assign last = (idx == head.cnt - 2'd1);
  assign cur  = head.recs[idx];
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= 2'd0;
      tokens.valid <= 1'b0;
    end else begin
      if (load) begin
        idx          <= last ? 2'd0 : idx + 2'd1;
        tokens.valid <= 1'b1;
      end else if (tokens.ready) begin
        tokens.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tokens.token_kind   <= cur.kind;
      tokens.name_start   <= cur.name_start;
      tokens.name_length  <= cur.name_length;
      tokens.value_start  <= cur.value_start;
      tokens.value_length <= cur.value_length;
      tokens.run_end      <= last;
    end
  end

endmodule

// File: rtl/json_token_scanner_core.sv
// json token scanner top level
//
// usage: bytes of a json buffer enter on the text channel, one request per
// byte, with final_byte set on the last byte of the buffer. token events
// leave on the tokens channel, one request per event; run_end marks the last
// event caused by one byte. a byte that causes no event produces nothing.
// throughput: one byte per cycle while the queue is not full. the front keeps
// the whole scanner state in one register stage and settles each byte in the
// cycle it is taken; the back sends one event per cycle while the receiver is
// ready, so a byte with two or three events (closing bracket after a value,
// end of buffer) holds the back for each event, and the two-entry queue
// absorbs it. a byte's tokens pass through the queue and the output register.
// reset (rst, synchronous) clears the scanner state to the start of a buffer
// and empties the queue and the output register.
// when the receiver stalls, the output register holds its token, the queue
// fills, and text.ready drops once both queue entries are occupied.
module json_token_scanner_core #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  jts_byte_if.sink    text,
  jts_token_if.source tokens
);
  import jts_pkg::*;

  push_t  push;
  logic   full;
  logic   head_valid;
  group_t head;
  logic   pop;

  jts_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .full (full),
    .push (push)
  );

  jts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  jts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tokens     (tokens)
  );

endmodule

// File: rtl/jts_checker.sv
// port-level checks for the json token scanner
module jts_checker (
  input logic        clk,
  input logic        rst,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic [2:0]  tok_kind,
  input logic [15:0] tok_name_length,
  input logic [15:0] tok_value_length,
  input logic        tok_run_end
);
  import jts_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid)
    else $error("token request dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !tok_valid)
    else $error("token request right after reset");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok_kind == KIND_OBJECT || tok_kind == KIND_ARRAY ||
                   tok_kind == KIND_END || tok_kind == KIND_VALUE ||
                   tok_kind == KIND_BUFEND))
    else $error("bad token kind");

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind == KIND_END |-> tok_name_length == '0 && tok_value_length == '0)
    else $error("container end carries name or value");

  a_bufend_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind == KIND_BUFEND |-> tok_run_end)
    else $error("buffer end not last of its run");

endmodule

bind json_token_scanner_core jts_checker u_jts_checker (
  .clk              (clk),
  .rst              (rst),
  .tok_valid        (tokens.valid),
  .tok_ready        (tokens.ready),
  .tok_kind         (tokens.token_kind),
  .tok_name_length  (tokens.name_length),
  .tok_value_length (tokens.value_length),
  .tok_run_end      (tokens.run_end)
);
